@@ hw/rtl/mlm_pkg.sv @@
// Shared types and constants for the mutex lock manager.
// Used by mlm_ctrl, mlm_datapath and the top level; depends on nothing.

package mlm_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ID_COUNT = 16;

  // Configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_IDX_ENABLED = 1'b0;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_QFULL     = 3'd6;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, start wait-queue read
    logic commit;   // update table, load result register
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/mlm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the per-mutex wait queues; no package dependencies.

module mlm_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/mlm_ctrl.sv @@
// Request sequencer for the mutex lock manager: two-state FSM and result valid.
// Depends on mlm_pkg for the state type and the command struct.

module mlm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mlm_pkg::ctrl_cmd_t cmd
);

  mlm_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mlm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.commit     = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      mlm_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = mlm_pkg::S_EXEC;
        end
      end
      mlm_pkg::S_EXEC: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = mlm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mlm_pkg::S_IDLE;
      end
    endcase
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == mlm_pkg::S_EXEC)
    else $error("capture did not move to execute");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid rose without a commit");

  a_stall_holds_exec: assert property (@(posedge clk) disable iff (rst)
    (state == mlm_pkg::S_EXEC && out_valid && !out_ready) |=>
      (state == mlm_pkg::S_EXEC && out_valid))
    else $error("execute left while result still stalled");

  a_no_commit_in_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (state == mlm_pkg::S_EXEC && !cmd.capture))
    else $error("commit outside execute");

endmodule

@@ hw/rtl/mlm_datapath.sv @@
// Datapath of the mutex lock manager: enable register, mutex table,
// wait-queue RAM and result register. Depends on mlm_pkg and mlm_ram.

module mlm_datapath #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mlm_pkg::ctrl_cmd_t            cmd,
  input  logic [mlm_pkg::CMD_W-1:0]     command,
  input  logic [mlm_pkg::ID_W-1:0]      mutex_id,
  input  logic [mlm_pkg::ID_W-1:0]      thread_id,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mlm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mlm_pkg::PDATA_W-1:0]   prdata,
  output logic [mlm_pkg::STATUS_W-1:0]  status,
  output logic [mlm_pkg::ID_W-1:0]      new_mutex_id,
  output logic                          woken_valid,
  output logic [mlm_pkg::ID_W-1:0]      woken_thread
);

  localparam int unsigned NID_W  = $clog2(NUM_MUTEXES + 1);
  localparam int unsigned CMP_W  = (NID_W > mlm_pkg::ID_W) ? NID_W : mlm_pkg::ID_W;
  localparam int unsigned SLOT_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WAITERS + 1);
  localparam int unsigned QDEPTH  = mlm_pkg::ID_COUNT << SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WAITERS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_WAITERS);
  localparam logic [NID_W-1:0]  NID_FULL  = NID_W'(NUM_MUTEXES);

  logic                          enabled;
  logic [NID_W-1:0]              next_id;
  logic [mlm_pkg::ID_COUNT-1:0]  locked;
  logic [mlm_pkg::ID_W-1:0]      owner [mlm_pkg::ID_COUNT];
  logic [CNT_W-1:0]              count [mlm_pkg::ID_COUNT];
  logic [SLOT_W-1:0]             head  [mlm_pkg::ID_COUNT];
  logic [SLOT_W-1:0]             tail  [mlm_pkg::ID_COUNT];

  logic [mlm_pkg::CMD_W-1:0]     req_cmd;
  logic [mlm_pkg::ID_W-1:0]      req_m;
  logic [mlm_pkg::ID_W-1:0]      req_t;
  logic [mlm_pkg::ID_W-1:0]      q_rdata;

  logic                          id_valid;
  logic                          do_alloc, do_grant, do_queue, do_handoff, do_free;
  logic [mlm_pkg::STATUS_W-1:0]  res_status;
  logic [SLOT_W-1:0]             head_next, tail_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == mlm_pkg::REG_IDX_ENABLED) begin
      enabled <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == mlm_pkg::REG_IDX_ENABLED) ?
                  {{(mlm_pkg::PDATA_W-1){1'b0}}, enabled} : '0;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd <= command;
      req_m   <= mutex_id;
      req_t   <= thread_id;
    end
  end

  // Head waiter is fetched at capture so it is ready at commit
  mlm_ram #(
    .WIDTH (mlm_pkg::ID_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.commit && do_queue),
    .waddr ({req_m, tail[req_m]}),
    .wdata (req_t),
    .re    (cmd.capture),
    .raddr ({mutex_id, head[mutex_id]}),
    .rdata (q_rdata)
  );

  assign id_valid  = CMP_W'(req_m) < CMP_W'(next_id);
  assign head_next = (head[req_m] == SLOT_LAST) ? '0 : head[req_m] + 1'b1;
  assign tail_next = (tail[req_m] == SLOT_LAST) ? '0 : tail[req_m] + 1'b1;

  always_comb begin
    do_alloc   = 1'b0;
    do_grant   = 1'b0;
    do_queue   = 1'b0;
    do_handoff = 1'b0;
    do_free    = 1'b0;
    res_status = mlm_pkg::ST_REFUSED;
    unique case (req_cmd)
      mlm_pkg::CMD_INIT: begin
        if (enabled && next_id != NID_FULL) begin
          do_alloc   = 1'b1;
          res_status = mlm_pkg::ST_OK;
        end
      end
      mlm_pkg::CMD_LOCK: begin
        if (!enabled) begin
          res_status = mlm_pkg::ST_REFUSED;
        end else if (!id_valid) begin
          res_status = mlm_pkg::ST_INVALID;
        end else if (locked[req_m]) begin
          if (count[req_m] >= CNT_FULL) begin
            res_status = mlm_pkg::ST_QFULL;
          end else begin
            do_queue   = 1'b1;
            res_status = mlm_pkg::ST_QUEUED;
          end
        end else begin
          do_grant   = 1'b1;
          res_status = mlm_pkg::ST_OK;
        end
      end
      mlm_pkg::CMD_UNLOCK: begin
        if (!id_valid) begin
          res_status = mlm_pkg::ST_INVALID;
        end else if (!locked[req_m] || owner[req_m] != req_t) begin
          res_status = mlm_pkg::ST_NOT_OWNER;
        end else if (count[req_m] != '0) begin
          do_handoff = 1'b1;
          res_status = mlm_pkg::ST_OK;
        end else begin
          do_free    = 1'b1;
          res_status = mlm_pkg::ST_OK;
        end
      end
      default: begin
        res_status = mlm_pkg::ST_REFUSED;
      end
    endcase
  end

  // Mutex table; entries of unallocated ids stay at their reset value,
  // so init needs no clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= '0;
      locked  <= '0;
      for (int i = 0; i < mlm_pkg::ID_COUNT; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
        tail[i]  <= '0;
      end
    end else if (cmd.commit) begin
      if (do_alloc) begin
        next_id <= next_id + 1'b1;
      end
      if (do_grant) begin
        locked[req_m] <= 1'b1;
      end
      if (do_free) begin
        locked[req_m] <= 1'b0;
      end
      if (do_queue) begin
        tail[req_m]  <= tail_next;
        count[req_m] <= count[req_m] + 1'b1;
      end
      if (do_handoff) begin
        head[req_m]  <= head_next;
        count[req_m] <= count[req_m] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_grant) begin
        owner[req_m] <= req_t;
      end else if (do_handoff) begin
        owner[req_m] <= q_rdata;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= res_status;
      new_mutex_id <= do_alloc ? mlm_pkg::ID_W'(CMP_W'(next_id)) : '0;
      woken_valid  <= do_handoff;
      woken_thread <= do_handoff ? q_rdata : '0;
    end
  end

  a_single_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({do_alloc, do_grant, do_queue, do_handoff, do_free}))
    else $error("more than one table action selected");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_queue) |=> count[$past(req_m)] <= CNT_FULL)
    else $error("wait count above queue depth");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    next_id <= NID_FULL)
    else $error("mutex ids handed out beyond table size");

endmodule

@@ hw/rtl/mutex_lock_manager_fifo_handoff_core.sv @@
// Mutex lock manager: a table of mutexes, each with an owner and a FIFO of
// waiting threads.
//
// Requests arrive on in_valid/in_ready with command (init, lock, unlock),
// mutex_id and thread_id. Each request yields exactly one result on
// out_valid/out_ready: status, new_mutex_id, woken_valid, woken_thread.
// Init hands out mutex ids from 0 upward; lock grants a free mutex or queues
// the caller; unlock by the owner hands it to the head waiter or frees it.
//
// A taken request is latched and starts the registered wait-queue RAM read
// of its head waiter; execute then updates the table and loads the result
// register, raising out_valid. New requests are taken only in idle.
// A stalled result holds in the output register; the next request is still
// taken and waits in execute until the result register frees up.
//
// Reset clears the enable register, the id counter and the per-mutex lock
// flags, counts and queue pointers at once; no clearing pass is needed.
// User writes enable register (APB, offset 0) only while idle; not checked.

module mutex_lock_manager_fifo_handoff_core #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mlm_pkg::CMD_W-1:0]     command,
  input  logic [mlm_pkg::ID_W-1:0]      mutex_id,
  input  logic [mlm_pkg::ID_W-1:0]      thread_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mlm_pkg::STATUS_W-1:0]  status,
  output logic [mlm_pkg::ID_W-1:0]      new_mutex_id,
  output logic                          woken_valid,
  output logic [mlm_pkg::ID_W-1:0]      woken_thread,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mlm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mlm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  mlm_pkg::ctrl_cmd_t cmd;

  assign pready = 1'b1;

  mlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mlm_datapath #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .MAX_WAITERS (MAX_WAITERS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .command      (command),
    .mutex_id     (mutex_id),
    .thread_id    (thread_id),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .status       (status),
    .new_mutex_id (new_mutex_id),
    .woken_valid  (woken_valid),
    .woken_thread (woken_thread)
  );

endmodule

@@ bench/mutex_lock_manager_fifo_handoff_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mutex_lock_manager_fifo_handoff_core: a short request list,
// then random init/lock/unlock traffic checked against a mutex table model kept here.
// Depends on mlm_pkg and the core RTL only.

module mutex_lock_manager_fifo_handoff_core_test;

  localparam int unsigned WAIT_DEPTH = 16;
  localparam logic [mlm_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [mlm_pkg::PADDR_W-1:0] ENABLE_ADDR =
    mlm_pkg::PADDR_W'(4 * mlm_pkg::REG_IDX_ENABLED);
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [mlm_pkg::STATUS_W-1:0] status;
    logic [mlm_pkg::ID_W-1:0]     new_id;
    logic                         woken_valid;
    logic [mlm_pkg::ID_W-1:0]     woken_thread;
  } outcome_t;

  typedef struct packed {
    logic                      enable;
    logic [mlm_pkg::CMD_W-1:0] cmd;
    logic [mlm_pkg::ID_W-1:0]  mutex;
    logic [mlm_pkg::ID_W-1:0]  thread;
    logic                      pinned;
    outcome_t                  want;
  } step_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [mlm_pkg::CMD_W-1:0]    command;
  logic [mlm_pkg::ID_W-1:0]     mutex_id;
  logic [mlm_pkg::ID_W-1:0]     thread_id;
  logic                         out_valid;
  logic                         out_ready;
  logic [mlm_pkg::STATUS_W-1:0] status;
  logic [mlm_pkg::ID_W-1:0]     new_mutex_id;
  logic                         woken_valid;
  logic [mlm_pkg::ID_W-1:0]     woken_thread;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mlm_pkg::PADDR_W-1:0]  paddr;
  logic [mlm_pkg::PDATA_W-1:0]  pwdata;
  logic [mlm_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // Mutex table model
  logic                     enable_reg;
  int unsigned              ids_issued;
  logic                     held      [mlm_pkg::ID_COUNT];
  logic [mlm_pkg::ID_W-1:0] owner     [mlm_pkg::ID_COUNT];
  int unsigned              waiters   [mlm_pkg::ID_COUNT];
  int unsigned              q_head    [mlm_pkg::ID_COUNT];
  int unsigned              q_tail    [mlm_pkg::ID_COUNT];
  logic [mlm_pkg::ID_W-1:0] wait_fifo [mlm_pkg::ID_COUNT][WAIT_DEPTH];

  outcome_t    pending_results[$];
  int unsigned mismatches = 0;
  bit          gaps_on = 1'b1;

  mutex_lock_manager_fifo_handoff_core #(
    .NUM_MUTEXES(mlm_pkg::ID_COUNT),
    .MAX_WAITERS(WAIT_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .mutex_id(mutex_id),
    .thread_id(thread_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .new_mutex_id(new_mutex_id),
    .woken_valid(woken_valid),
    .woken_thread(woken_thread),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic outcome_t answer(input logic [mlm_pkg::STATUS_W-1:0] s,
                                      input logic [mlm_pkg::ID_W-1:0] id,
                                      input logic wv, input logic [mlm_pkg::ID_W-1:0] wt);
    outcome_t r;
    r.status = s;
    r.new_id = id;
    r.woken_valid = wv;
    r.woken_thread = wt;
    return r;
  endfunction

  function automatic step_t pinned(input logic en, input logic [mlm_pkg::CMD_W-1:0] c,
                                   input logic [mlm_pkg::ID_W-1:0] m,
                                   input logic [mlm_pkg::ID_W-1:0] t,
                                   input outcome_t want);
    step_t s;
    s.enable = en;
    s.cmd = c;
    s.mutex = m;
    s.thread = t;
    s.pinned = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic step_t checked(input logic en, input logic [mlm_pkg::CMD_W-1:0] c,
                                    input logic [mlm_pkg::ID_W-1:0] m,
                                    input logic [mlm_pkg::ID_W-1:0] t);
    step_t s;
    s = pinned(en, c, m, t, '0);
    s.pinned = 1'b0;
    return s;
  endfunction

  function automatic void clear_table();
    enable_reg = 1'b0;
    ids_issued = 0;
    for (int i = 0; i < mlm_pkg::ID_COUNT; i++) begin
      held[i] = 1'b0;
      waiters[i] = 0;
      q_head[i] = 0;
      q_tail[i] = 0;
    end
  endfunction

  // Apply one request to the table model and return the result it must produce.
  function automatic outcome_t apply_request(input logic [mlm_pkg::CMD_W-1:0] cmd,
                                             input logic [mlm_pkg::ID_W-1:0] m,
                                             input logic [mlm_pkg::ID_W-1:0] t);
    outcome_t r;
    logic     known;
    r = '0;
    r.status = mlm_pkg::ST_REFUSED;
    known = (m < ids_issued);
    case (cmd)
      mlm_pkg::CMD_INIT: begin
        if (enable_reg && ids_issued < mlm_pkg::ID_COUNT) begin
          r.new_id = mlm_pkg::ID_W'(ids_issued);
          held[ids_issued] = 1'b0;
          waiters[ids_issued] = 0;
          q_head[ids_issued] = 0;
          q_tail[ids_issued] = 0;
          ids_issued++;
          r.status = mlm_pkg::ST_OK;
        end
      end
      mlm_pkg::CMD_LOCK: begin
        if (!enable_reg) begin
          r.status = mlm_pkg::ST_REFUSED;
        end else if (!known) begin
          r.status = mlm_pkg::ST_INVALID;
        end else if (held[m]) begin
          if (waiters[m] >= WAIT_DEPTH) begin
            r.status = mlm_pkg::ST_QFULL;
          end else begin
            // owner and queued threads are appended again like anyone else
            wait_fifo[m][q_tail[m]] = t;
            q_tail[m] = (q_tail[m] + 1) % WAIT_DEPTH;
            waiters[m]++;
            r.status = mlm_pkg::ST_QUEUED;
          end
        end else begin
          held[m] = 1'b1;
          owner[m] = t;
          r.status = mlm_pkg::ST_OK;
        end
      end
      mlm_pkg::CMD_UNLOCK: begin
        if (!known) begin
          r.status = mlm_pkg::ST_INVALID;
        end else if (!held[m] || owner[m] != t) begin
          r.status = mlm_pkg::ST_NOT_OWNER;
        end else if (waiters[m] != 0) begin
          // hand off to the head waiter
          r.woken_thread = wait_fifo[m][q_head[m]];
          r.woken_valid = 1'b1;
          q_head[m] = (q_head[m] + 1) % WAIT_DEPTH;
          waiters[m]--;
          owner[m] = r.woken_thread;
          r.status = mlm_pkg::ST_OK;
        end else begin
          held[m] = 1'b0;
          r.status = mlm_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [mlm_pkg::CMD_W-1:0] cmd,
                              input logic [mlm_pkg::ID_W-1:0] m,
                              input logic [mlm_pkg::ID_W-1:0] t, input logic use_pinned,
                              input outcome_t want);
    outcome_t predicted;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    mutex_id  <= m;
    thread_id <= t;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = apply_request(cmd, m, t);
    pending_results.push_back(use_pinned ? want : predicted);
  endtask

  // Drain outstanding results, then write the enable register and read it back.
  task automatic set_enable(input logic value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= {{(mlm_pkg::PDATA_W-1){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    enable_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== {{(mlm_pkg::PDATA_W-1){1'b0}}, value})
      note_mismatch($sformatf("enable readback %0h, expected %0h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input logic en, input int unsigned count, input bit with_gaps);
    logic [mlm_pkg::CMD_W-1:0] cmd;
    logic [mlm_pkg::ID_W-1:0]  m;
    logic [mlm_pkg::ID_W-1:0]  t;
    int unsigned               pick;
    if (en !== enable_reg) set_enable(en);
    gaps_on = with_gaps;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) cmd = mlm_pkg::CMD_INIT;
      else if (pick < 9) cmd = CMD_SPARE;
      else if (pick < 55) cmd = mlm_pkg::CMD_LOCK;
      else cmd = mlm_pkg::CMD_UNLOCK;
      // crowd two mutexes so their wait queues fill and wrap
      if ($urandom_range(0, 1) == 0) m = mlm_pkg::ID_W'($urandom_range(0, 1));
      else m = mlm_pkg::ID_W'($urandom_range(0, mlm_pkg::ID_COUNT - 1));
      t = mlm_pkg::ID_W'($urandom_range(0, 15));
      if (cmd == mlm_pkg::CMD_UNLOCK && held[m] && $urandom_range(0, 3) != 0) t = owner[m];
      send_request(cmd, m, t, 1'b0, '0);
    end
  endtask

  // Result side: check each accepted result, stall in random bursts while gaps are on.
  initial begin
    int unsigned hold_off;
    outcome_t    want;
    hold_off = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with no request pending");
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (new_mutex_id !== want.new_id)
            note_mismatch($sformatf("new_mutex_id %0d, expected %0d", new_mutex_id,
                                    want.new_id));
          if (woken_valid !== want.woken_valid)
            note_mismatch($sformatf("woken_valid %0d, expected %0d", woken_valid,
                                    want.woken_valid));
          if (woken_thread !== want.woken_thread)
            note_mismatch($sformatf("woken_thread %0d, expected %0d", woken_thread,
                                    want.woken_thread));
        end
      end
      if (hold_off != 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        hold_off = $urandom_range(0, 13);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid & in_ready) === 1'b1 || (out_valid & out_ready) === 1'b1 ||
          (psel & penable) === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    step_t plan[$];
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= mlm_pkg::CMD_INIT;
    mutex_id  <= '0;
    thread_id <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    clear_table();

    // disabled: init and lock refused, unlock of an unknown id, spare command
    plan.push_back(pinned(1'b0, mlm_pkg::CMD_INIT, 4'd0, 4'd0,
                          answer(mlm_pkg::ST_REFUSED, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b0, mlm_pkg::CMD_LOCK, 4'd0, 4'd15,
                          answer(mlm_pkg::ST_REFUSED, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b0, mlm_pkg::CMD_UNLOCK, 4'd15, 4'd15,
                          answer(mlm_pkg::ST_INVALID, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b0, CMD_SPARE, 4'd15, 4'd0,
                          answer(mlm_pkg::ST_REFUSED, 4'd0, 1'b0, 4'd0)));
    // enabled: first ids, mutex_id ignored by init
    plan.push_back(pinned(1'b1, mlm_pkg::CMD_INIT, 4'd15, 4'd9,
                          answer(mlm_pkg::ST_OK, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b1, mlm_pkg::CMD_INIT, 4'd0, 4'd9,
                          answer(mlm_pkg::ST_OK, 4'd1, 1'b0, 4'd0)));
    // grant, queue a waiter, owner queues itself again
    plan.push_back(checked(1'b1, mlm_pkg::CMD_LOCK, 4'd0, 4'd15));
    plan.push_back(checked(1'b1, mlm_pkg::CMD_LOCK, 4'd0, 4'd0));
    plan.push_back(checked(1'b1, mlm_pkg::CMD_LOCK, 4'd0, 4'd15));
    plan.push_back(pinned(1'b1, mlm_pkg::CMD_UNLOCK, 4'd0, 4'd0,
                          answer(mlm_pkg::ST_NOT_OWNER, 4'd0, 1'b0, 4'd0)));
    // hand off twice, then free
    plan.push_back(checked(1'b1, mlm_pkg::CMD_UNLOCK, 4'd0, 4'd15));
    plan.push_back(checked(1'b1, mlm_pkg::CMD_UNLOCK, 4'd0, 4'd0));
    plan.push_back(checked(1'b1, mlm_pkg::CMD_UNLOCK, 4'd0, 4'd15));
    // unlock of a free mutex has no owner to match
    plan.push_back(pinned(1'b1, mlm_pkg::CMD_UNLOCK, 4'd0, 4'd15,
                          answer(mlm_pkg::ST_NOT_OWNER, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b1, mlm_pkg::CMD_LOCK, 4'd15, 4'd3,
                          answer(mlm_pkg::ST_INVALID, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b1, mlm_pkg::CMD_UNLOCK, 4'd2, 4'd12,
                          answer(mlm_pkg::ST_INVALID, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b1, CMD_SPARE, 4'd0, 4'd15,
                          answer(mlm_pkg::ST_REFUSED, 4'd0, 1'b0, 4'd0)));
    plan.push_back(checked(1'b1, mlm_pkg::CMD_LOCK, 4'd1, 4'd7));
    // disabled again: unlock still works
    plan.push_back(pinned(1'b0, mlm_pkg::CMD_LOCK, 4'd1, 4'd2,
                          answer(mlm_pkg::ST_REFUSED, 4'd0, 1'b0, 4'd0)));
    plan.push_back(pinned(1'b0, mlm_pkg::CMD_INIT, 4'd0, 4'd0,
                          answer(mlm_pkg::ST_REFUSED, 4'd0, 1'b0, 4'd0)));
    plan.push_back(checked(1'b0, mlm_pkg::CMD_UNLOCK, 4'd1, 4'd7));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_enable(1'b0);

    foreach (plan[i]) begin
      if (plan[i].enable !== enable_reg) set_enable(plan[i].enable);
      send_request(plan[i].cmd, plan[i].mutex, plan[i].thread, plan[i].pinned, plan[i].want);
    end

    run_random(1'b1, 300, 1'b1);
    run_random(1'b0, 60, 1'b1);
    run_random(1'b1, 550, 1'b1);
    run_random(1'b0, 40, 1'b1);
    run_random(1'b1, 150, 1'b0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mlm_pkg.sv
hw/rtl/mlm_ram.sv
hw/rtl/mlm_ctrl.sv
hw/rtl/mlm_datapath.sv
hw/rtl/mutex_lock_manager_fifo_handoff_core.sv
bench/mutex_lock_manager_fifo_handoff_core_test.sv
